// ===== rtl/core/stable_priority_queue_unit_assert.svh =====
// Assertion macros for the stable priority queue unit.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds in the same cycle as the trigger.
`define SPQ_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("spq assertion failed");

// Condition holds in the cycle after the trigger.
`define SPQ_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT_SAME(label, trig, cond)
`define SPQ_ASSERT_NEXT(label, trig, cond)

`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and defaults of the stable priority queue.
package spq_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_KEY_BITS  = 16;
    localparam int DEF_PRIO_BITS = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SERVE  = 2'd2
    } spq_action_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } spq_status_t;

    // Per-beat command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
        logic srv;
    } spq_cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS  = DEF_KEY_BITS,
    parameter int PRIO_BITS = DEF_PRIO_BITS
)
(
    input  logic                 clk,
    input  spq_cmd_t             cmd,
    input  logic [KEY_BITS-1:0]  new_key,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic                 occ,
    input  logic                 at_tail,
    input  logic                 left_shift,
    input  logic [KEY_BITS-1:0]  left_key,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [KEY_BITS-1:0]  right_key,
    input  logic [PRIO_BITS-1:0] right_prio,
    input  logic                 seen_in,
    output logic                 seen_out,
    output logic                 hit,
    output logic                 shift_out,
    output logic [KEY_BITS-1:0]  key,
    output logic [PRIO_BITS-1:0] prio
);

    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;
    logic                 occ_gt;
    logic                 match;

    always_comb
    begin
        occ_gt   = occ & (prio_reg > new_prio);
        match    = occ & (key_reg == new_key);
        hit      = match & ~seen_in;
        seen_out = seen_in | match;

        key_next  = key_reg;
        prio_next = prio_reg;
        if (cmd.ins)
        begin
            // entries past the insertion point move one slot toward the tail
            if (left_shift)
            begin
                key_next  = left_key;
                prio_next = left_prio;
            end
            else if (occ_gt | at_tail)
            begin
                key_next  = new_key;
                prio_next = new_prio;
            end
        end
        else if (cmd.srv | (cmd.rem & seen_out))
        begin
            // close the gap left by the removed entry
            key_next  = right_key;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

    assign shift_out = occ_gt;
    assign key       = key_reg;
    assign prio      = prio_reg;

endmodule

// ===== rtl/core/stable_priority_queue_unit.sv =====
// Stable priority queue: a chain of slot cells kept in ascending priority order.
//
// Request channel (req_valid / req_stall) carries action, entry_key and
// entry_priority. Insert places the entry after every entry of lower or equal
// priority; remove deletes the first entry with a matching key; serve pops the
// head. Response channel (rsp_valid / rsp_stall) returns one beat per request:
// status, out_key, out_priority and occupancy after the action.
// The response is registered: it appears the cycle after the request beat.
// Throughput is one request per cycle while req_stall is low; every cell compares
// its entry with the request and shifts against its neighbor in that same cycle.
// While a response waits under rsp_stall, req_stall is raised and the response
// holds; a new request is taken in the same cycle the waiting response leaves.
// Reset leaves the queue empty with no response pending; slot contents are not
// cleared, slots beyond the occupancy are never read.
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_BITS  = DEF_KEY_BITS,
    parameter int PRIO_BITS = DEF_PRIO_BITS,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           action,
    input  logic [KEY_BITS-1:0]  entry_key,
    input  logic [PRIO_BITS-1:0] entry_priority,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [1:0]           status,
    output logic [KEY_BITS-1:0]  out_key,
    output logic [PRIO_BITS-1:0] out_priority,
    output logic [CNT_W-1:0]     occupancy
);

`include "stable_priority_queue_unit_assert.svh"

    logic                 req_fire;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [KEY_BITS-1:0]  okey_reg;
    logic [KEY_BITS-1:0]  okey_next;
    logic [PRIO_BITS-1:0] oprio_reg;
    logic [PRIO_BITS-1:0] oprio_next;
    spq_cmd_t             cmd;

    logic [KEY_BITS-1:0]  key_w   [CAPACITY];
    logic [PRIO_BITS-1:0] prio_w  [CAPACITY];
    logic [CAPACITY-1:0]  shift_w;
    logic [CAPACITY-1:0]  hit_vec;
    logic [CAPACITY:0]    seen;
    logic [KEY_BITS-1:0]  hit_key;
    logic [PRIO_BITS-1:0] hit_prio;
    logic                 full;
    logic                 empty;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign req_fire  = req_valid & ~req_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign seen[0]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                 l_shift;
            logic [KEY_BITS-1:0]  l_key;
            logic [PRIO_BITS-1:0] l_prio;
            logic [KEY_BITS-1:0]  r_key;
            logic [PRIO_BITS-1:0] r_prio;

            if (gi == 0)
            begin : g_head
                assign l_shift = 1'b0;
                assign l_key   = '0;
                assign l_prio  = '0;
            end
            else
            begin : g_mid
                assign l_shift = shift_w[gi-1];
                assign l_key   = key_w[gi-1];
                assign l_prio  = prio_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_key  = '0;
                assign r_prio = '0;
            end
            else
            begin : g_body
                assign r_key  = key_w[gi+1];
                assign r_prio = prio_w[gi+1];
            end

            spq_cell #(
                .KEY_BITS  (KEY_BITS),
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .new_key    (entry_key),
                .new_prio   (entry_priority),
                .occ        (count_reg > CNT_W'(gi)),
                .at_tail    (count_reg == CNT_W'(gi)),
                .left_shift (l_shift),
                .left_key   (l_key),
                .left_prio  (l_prio),
                .right_key  (r_key),
                .right_prio (r_prio),
                .seen_in    (seen[gi]),
                .seen_out   (seen[gi+1]),
                .hit        (hit_vec[gi]),
                .shift_out  (shift_w[gi]),
                .key        (key_w[gi]),
                .prio       (prio_w[gi])
            );
        end
    endgenerate

    // at most one cell flags the first match, so an OR picks its entry
    always_comb
    begin
        hit_key  = '0;
        hit_prio = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_key  = hit_key  | ({KEY_BITS{hit_vec[i]}} & key_w[i]);
            hit_prio = hit_prio | ({PRIO_BITS{hit_vec[i]}} & prio_w[i]);
        end
    end

    always_comb
    begin
        cmd         = '0;
        count_next  = count_reg;
        status_next = ST_MISS;
        okey_next   = '0;
        oprio_next  = '0;
        case (action)
            ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins     = req_fire;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_DONE;
                end
            end
            ACT_REMOVE:
            begin
                if (seen[CAPACITY])
                begin
                    cmd.rem     = req_fire;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_DONE;
                    okey_next   = hit_key;
                    oprio_next  = hit_prio;
                end
            end
            ACT_SERVE:
            begin
                if (!empty)
                begin
                    cmd.srv     = req_fire;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_DONE;
                    okey_next   = key_w[0];
                    oprio_next  = prio_w[0];
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            status_reg <= status_next;
            okey_reg   <= okey_next;
            oprio_reg  <= oprio_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_key      = okey_reg;
    assign out_priority = oprio_reg;
    assign occupancy    = count_reg;

    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_SAME(a_first_hit_unique, 1'b1, $onehot0(hit_vec))
    `SPQ_ASSERT_NEXT(a_insert_grows,
        req_fire && action == ACT_INSERT && !full,
        rsp_valid && status == ST_DONE && occupancy == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT_SAME(a_miss_zero_data,
        rsp_valid && status != ST_DONE,
        out_key == '0 && out_priority == '0)

endmodule
